@@ hw/rtl/gmfb_pkg.sv @@
// ----------------------------------------------------------------------------
// gmfb_pkg
// Shared types, codes and constants of the mailbox frame buffer setup block.
// ----------------------------------------------------------------------------
package gmfb_pkg;

  // Default for the dimension mask width
  localparam int MaxDimBitsDefault = 12;

  // Field widths
  localparam int OpW    = 2;
  localparam int AddrW  = 32;
  localparam int WordW  = 32;
  localparam int DimW   = 12;
  localparam int DepthW = 6;
  localparam int KindW  = 2;
  localparam int PitchW = 14;
  localparam int SizeW  = 26;
  localparam int IdxW   = 4;
  localparam int BppW   = 3;
  localparam int CfgIndexW = 1;

  // Operations
  localparam logic [OpW-1:0] OP_READ  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_TICK  = 2'd2;
  localparam logic [OpW-1:0] OP_REPLY = 2'd3;

  // Result kinds
  localparam logic [KindW-1:0] KIND_DONE   = 2'd0;
  localparam logic [KindW-1:0] KIND_NONE   = 2'd1;
  localparam logic [KindW-1:0] KIND_FETCH  = 2'd2;
  localparam logic [KindW-1:0] KIND_ANSWER = 2'd3;

  // Word indexes inside the window
  localparam logic [IdxW-1:0] WORD_READ   = 4'd0;
  localparam logic [IdxW-1:0] WORD_RSV0   = 4'd1;
  localparam logic [IdxW-1:0] WORD_RSV1   = 4'd2;
  localparam logic [IdxW-1:0] WORD_RSV2   = 4'd3;
  localparam logic [IdxW-1:0] WORD_POLL   = 4'd4;
  localparam logic [IdxW-1:0] WORD_SENDER = 4'd5;
  localparam logic [IdxW-1:0] WORD_STATUS = 4'd6;
  localparam logic [IdxW-1:0] WORD_CONFIG = 4'd7;
  localparam logic [IdxW-1:0] WORD_WRITE  = 4'd8;
  localparam logic [AddrW-3:0] WINDOW_WORDS = 30'd9;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_MAILBOX_BASE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_FB_END       = 1'b1;

  // Status bits (active low readiness)
  localparam int StatusReadBit  = 30;
  localparam int StatusWriteBit = 31;
  localparam logic [WordW-1:0] STATUS_RESET   = 32'h4000_0000;
  localparam logic [WordW-1:0] FETCH_MASK     = 32'h3fff_fff0;
  localparam logic [DepthW-1:0] DEPTH_MAX     = 6'd32;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [AddrW-1:0]  bus_address;
    logic [WordW-1:0]  write_data;
    logic [DimW-1:0]   virtual_width;
    logic [DimW-1:0]   virtual_height;
    logic [DepthW-1:0] bit_depth;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [WordW-1:0]  read_data;
    logic              in_window;
    logic [AddrW-1:0]  fetch_address;
    logic [PitchW-1:0] pitch;
    logic [SizeW-1:0]  buffer_size;
    logic [AddrW-1:0]  buffer_pointer;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic decode;
    logic calc_size;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/gmfb_if.sv @@
// ----------------------------------------------------------------------------
// gmfb interfaces
// Item, result and configuration channels of the mailbox block.
// ----------------------------------------------------------------------------
interface gmfb_req_if import gmfb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gmfb_rsp_if import gmfb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gmfb_cfg_if import gmfb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [WordW-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/gpu_mailbox_framebuffer_setup_core.sv @@
// The result beat reaches the output register through the decode, size and commit steps;
//   a full, unconsumed output register holds the commit step.
// A new item is taken only once the last one is committed, after the accept, decode with
//   pitch multiply, size multiply and commit steps of the controller.
// Reset: synchronous, active high; clears the mailbox words (status reads 0x40000000),
//   the configuration registers, pending flags and the output valid.
// ----------------------------------------------------------------------------
// gpu_mailbox_framebuffer_setup_core
// Mailbox register window with a frame buffer setup channel. Bus reads and
// writes reach nine words; mail in the write word triggers a descriptor fetch
// on a tick, and a descriptor reply is answered with pitch, size and pointer.
// ----------------------------------------------------------------------------
module gpu_mailbox_framebuffer_setup_core import gmfb_pkg::*; #(
  parameter int MAX_DIMENSION_BITS = MaxDimBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  gmfb_req_if.sink   req,
  gmfb_rsp_if.source rsp,
  gmfb_cfg_if.sink   cfg
);

  // Command and status between the sequencer and the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: accept a beat only when idle, then advance one step a cycle
  // and hold in the commit step while the output register is still full.
  gmfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: latch the item, decode the window hit and compute pitch, then
  // size, then commit the mailbox update together with the result beat.
  gmfb_dpath #(
    .MAX_DIMENSION_BITS (MAX_DIMENSION_BITS)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .item (req.data),
    .cfg  (cfg),
    .rsp  (rsp)
  );

endmodule

@@ hw/rtl/gmfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// gmfb_ctrl
// Sequencer: take one beat, step it through decode and size, then commit.
// ----------------------------------------------------------------------------
module gmfb_ctrl import gmfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SIZE   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_SIZE;
      end
      S_SIZE: begin
        cmd.calc_size = 1'b1;
        state_next    = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/gmfb_dpath.sv @@
// ----------------------------------------------------------------------------
// gmfb_dpath
// Mailbox words, configuration registers, pitch/size multipliers and the
// output register.
// ----------------------------------------------------------------------------
module gmfb_dpath import gmfb_pkg::*; #(
  parameter int MAX_DIMENSION_BITS = MaxDimBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  in_item_t          item,
  gmfb_cfg_if.sink          cfg,
  gmfb_rsp_if.source        rsp
);

  localparam logic [DimW-1:0] DimMask = (MAX_DIMENSION_BITS >= DimW) ? {DimW{1'b1}}
                                      : DimW'((1 << MAX_DIMENSION_BITS) - 1);

  // configuration
  logic [AddrW-1:0] mailbox_base;
  logic [AddrW-1:0] fb_end;

  // mailbox state
  logic [WordW-1:0] read_word;
  logic [WordW-1:0] rsv_words [3];
  logic [WordW-1:0] sender_word;
  logic [WordW-1:0] status_word;
  logic [WordW-1:0] config_word;
  logic [WordW-1:0] write_word;
  logic             mail_pending;
  logic             awaiting;

  // item and intermediate registers
  in_item_t         cur;
  logic             hit;
  logic [IdxW-1:0]  idx;
  logic [PitchW-1:0] pitch_q;
  logic [SizeW-1:0] size_q;

  // output register
  logic      out_valid;
  out_item_t out_data;

  logic [AddrW-3:0]  word_off;
  logic [DepthW-1:0] depth_c;
  logic [BppW-1:0]   bpp;
  logic [DimW-1:0]   vw_m;
  logic [DimW-1:0]   vh_m;
  logic [1:0]        rsv_idx;
  logic [WordW-1:0]  word_rd;
  out_item_t         res;

  assign cfg.ready     = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.data      = out_data;
  assign stat.out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mailbox_base <= '0;
      fb_end       <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MAILBOX_BASE: mailbox_base <= cfg.data;
        CFG_FB_END:       fb_end       <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // decode helpers
  assign word_off = cur.bus_address[AddrW-1:2] - mailbox_base[AddrW-1:2];
  assign depth_c  = (cur.bit_depth > DEPTH_MAX) ? DEPTH_MAX : cur.bit_depth;
  assign bpp      = BppW'((depth_c + DepthW'(7)) >> 3);
  assign vw_m     = cur.virtual_width & DimMask;
  assign vh_m     = cur.virtual_height & DimMask;
  assign rsv_idx  = 2'(idx - WORD_RSV0);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur <= item;
    end
    if (cmd.decode) begin
      hit     <= (word_off < WINDOW_WORDS);
      idx     <= word_off[IdxW-1:0];
      pitch_q <= PitchW'(vw_m) * PitchW'(bpp);
    end
    if (cmd.calc_size) begin
      size_q <= SizeW'(pitch_q) * SizeW'(vh_m);
    end
  end

  always_comb begin
    case (idx)
      WORD_READ:   word_rd = read_word;
      WORD_RSV0,
      WORD_RSV1,
      WORD_RSV2:   word_rd = rsv_words[rsv_idx];
      WORD_POLL:   word_rd = read_word;
      WORD_SENDER: word_rd = sender_word;
      WORD_STATUS: word_rd = status_word;
      WORD_CONFIG: word_rd = config_word;
      default:     word_rd = write_word;
    endcase
  end

  // result of the current item
  always_comb begin
    res      = '0;
    res.kind = KIND_NONE;
    case (cur.operation)
      OP_READ, OP_WRITE: begin
        res.kind      = KIND_DONE;
        res.in_window = hit;
        if (hit && cur.operation == OP_READ) begin
          res.read_data = word_rd;
        end
      end
      OP_TICK: begin
        if (mail_pending && !awaiting) begin
          res.kind          = KIND_FETCH;
          res.fetch_address = write_word & FETCH_MASK;
        end
      end
      default: begin
        if (awaiting) begin
          res.kind           = KIND_ANSWER;
          res.pitch          = pitch_q;
          res.buffer_size    = size_q;
          res.buffer_pointer = fb_end - AddrW'(size_q);
        end
      end
    endcase
  end

  // state update at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      read_word    <= '0;
      rsv_words[0] <= '0;
      rsv_words[1] <= '0;
      rsv_words[2] <= '0;
      sender_word  <= '0;
      status_word  <= STATUS_RESET;
      config_word  <= '0;
      write_word   <= '0;
      mail_pending <= 1'b0;
      awaiting     <= 1'b0;
    end else if (cmd.commit) begin
      case (cur.operation)
        OP_READ: begin
          if (hit && idx == WORD_READ) begin
            status_word[StatusReadBit] <= 1'b1;
          end
        end
        OP_WRITE: begin
          if (hit) begin
            case (idx)
              WORD_READ:   read_word <= cur.write_data;
              WORD_RSV0,
              WORD_RSV1,
              WORD_RSV2:   rsv_words[rsv_idx] <= cur.write_data;
              WORD_POLL: begin
              end
              WORD_SENDER: sender_word <= cur.write_data;
              WORD_STATUS: status_word <= cur.write_data;
              WORD_CONFIG: config_word <= cur.write_data;
              default: begin
                write_word <= cur.write_data;
                if (!status_word[StatusWriteBit]) begin
                  status_word[StatusWriteBit] <= 1'b1;
                  mail_pending                <= 1'b1;
                end
              end
            endcase
          end
        end
        OP_TICK: begin
          if (mail_pending && !awaiting) begin
            awaiting <= 1'b1;
          end
        end
        default: begin
          if (awaiting) begin
            read_word                   <= {{(WordW-4){1'b0}}, write_word[3:0]};
            status_word[StatusReadBit]  <= 1'b0;
            status_word[StatusWriteBit] <= 1'b0;
            mail_pending                <= 1'b0;
            awaiting                    <= 1'b0;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= res;
    end
  end

endmodule

@@ hw/rtl/gmfb_checker.sv @@
// ----------------------------------------------------------------------------
// gmfb_checker
// Port-level checks of the mailbox block, bound to the top level.
// ----------------------------------------------------------------------------
module gmfb_checker import gmfb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input out_item_t rsp_data
);

  // A result beat waits until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped before it was taken");

  // One item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("new beat taken while an item is at work");

  // No result right out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // Fetch address is aligned to 16 bytes and filtered to 30 bits
  a_fetch_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.kind == KIND_FETCH |->
      rsp_data.fetch_address[3:0] == 4'd0 && rsp_data.fetch_address[31:30] == 2'd0)
    else $error("fetch address not aligned or filtered");

  // Descriptor fields are zero except in a descriptor answer
  a_answer_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.kind != KIND_ANSWER |->
      rsp_data.pitch == '0 && rsp_data.buffer_size == '0 &&
      rsp_data.buffer_pointer == '0)
    else $error("descriptor fields set outside an answer");

endmodule

bind gpu_mailbox_framebuffer_setup_core gmfb_checker u_gmfb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mailbox frame buffer setup core. A driver and a
// receiver run on the falling edge with random gaps. A monitor samples every
// beat on the rising edge and steps a predictor of the mailbox words, the
// pending-mail flags and the descriptor arithmetic. Each result beat is
// checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
  import gmfb_pkg::*;

  localparam int HalfPeriod    = 2;
  localparam int ResetCycles   = 8;
  localparam int StallLimit    = 2000;
  localparam int HoldOffCycles = 120;
  localparam int PhaseItems    = 130;
  localparam int TailCycles    = 16;
  localparam int MaxReports    = 10;
  localparam int MaxDimBits    = MaxDimBitsDefault;

  localparam logic [WordW-1:0] WindowBytes = 32'd36;
  localparam logic [WordW-1:0] ChannelMask = 32'h0000_000f;
  localparam logic [WordW-1:0] DimMask     = (32'd1 << MaxDimBits) - 32'd1;

  localparam logic [OpW-1:0] OP_OPS [4] = '{OP_READ, OP_WRITE, OP_TICK, OP_REPLY};

  logic clk = 1'b0;
  logic rst = 1'b1;

  gmfb_req_if req_ch ();
  gmfb_rsp_if rsp_ch ();
  gmfb_cfg_if cfg_ch ();

  gpu_mailbox_framebuffer_setup_core #(
    .MAX_DIMENSION_BITS(MaxDimBits)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #(HalfPeriod) clk = ~clk;

  // Predicted state of the block: configuration, mailbox words and flags
  logic [WordW-1:0] win_base;
  logic [WordW-1:0] fb_end;
  logic [WordW-1:0] mb_read;
  logic [WordW-1:0] mb_rsv [3];
  logic [WordW-1:0] mb_sender;
  logic [WordW-1:0] mb_status;
  logic [WordW-1:0] mb_config;
  logic [WordW-1:0] mb_write;
  logic             mail_pend;
  logic             await_desc;

  // Pending request beats, predicted result beats, progress counters
  in_item_t  bus_op_q [$];
  out_item_t mailbox_out_q [$];
  out_item_t want;
  int        ops_queued = 0;
  int        ops_checked = 0;
  int        mismatch_count = 0;
  int        stall_cycles = 0;

  logic req_fire = 1'b0;
  logic calm = 1'b0;     // no random gaps on either side while set
  logic rx_hold = 1'b0;  // receiver held off by the pressure process
  event hold_off_ev;

  // --------------------------------------------------------------------------
  // Predictor: advance the mailbox by one accepted request and return the
  // result beat that it must produce.
  // --------------------------------------------------------------------------
  function automatic out_item_t mailbox_advance(in_item_t it);
    out_item_t        r;
    logic [WordW-1:0] offset;
    logic [WordW-1:0] width;
    logic [WordW-1:0] height;
    logic [WordW-1:0] bpp;
    logic [WordW-1:0] pitch;
    logic [WordW-1:0] size;
    logic [IdxW-1:0]  idx;
    logic [DepthW-1:0] depth;
    r = '0;
    r.kind = KIND_NONE;
    case (it.operation)
      OP_READ, OP_WRITE: begin
        r.kind = KIND_DONE;
        // Low two address bits are ignored on both sides; the window wraps mod 2^32
        offset = {it.bus_address[AddrW-1:2], 2'b00} - {win_base[AddrW-1:2], 2'b00};
        if (offset < WindowBytes) begin
          idx = offset[5:2];
          r.in_window = 1'b1;
          if (it.operation == OP_READ) begin
            case (idx)
              WORD_READ, WORD_POLL: r.read_data = mb_read;
              WORD_RSV0:   r.read_data = mb_rsv[0];
              WORD_RSV1:   r.read_data = mb_rsv[1];
              WORD_RSV2:   r.read_data = mb_rsv[2];
              WORD_SENDER: r.read_data = mb_sender;
              WORD_STATUS: r.read_data = mb_status;
              WORD_CONFIG: r.read_data = mb_config;
              default:     r.read_data = mb_write;
            endcase
            // Reading the read word drops read-ready
            if (idx == WORD_READ) mb_status[StatusReadBit] = 1'b1;
          end else begin
            case (idx)
              WORD_READ:   mb_read = it.write_data;
              WORD_RSV0:   mb_rsv[0] = it.write_data;
              WORD_RSV1:   mb_rsv[1] = it.write_data;
              WORD_RSV2:   mb_rsv[2] = it.write_data;
              WORD_POLL:   ;
              WORD_SENDER: mb_sender = it.write_data;
              WORD_STATUS: mb_status = it.write_data;
              WORD_CONFIG: mb_config = it.write_data;
              default:     mb_write = it.write_data;
            endcase
            // Mail only counts while write-ready; the word is stored regardless
            if (idx == WORD_WRITE && !mb_status[StatusWriteBit]) begin
              mb_status[StatusWriteBit] = 1'b1;
              mail_pend = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (mail_pend && !await_desc) begin
          r.kind = KIND_FETCH;
          r.fetch_address = mb_write & FETCH_MASK;
          await_desc = 1'b1;
        end
      end
      default: begin
        if (await_desc) begin
          depth  = (it.bit_depth > DEPTH_MAX) ? DEPTH_MAX : it.bit_depth;
          bpp    = (32'(depth) + 32'd7) >> 3;
          width  = 32'(it.virtual_width) & DimMask;
          height = 32'(it.virtual_height) & DimMask;
          pitch  = width * bpp;
          size   = pitch * height;
          r.kind = KIND_ANSWER;
          r.pitch = pitch[PitchW-1:0];
          r.buffer_size = size[SizeW-1:0];
          r.buffer_pointer = fb_end - size;
          // Hand the channel back and make the mailbox ready both ways
          mb_read = mb_write & ChannelMask;
          mb_status[StatusReadBit] = 1'b0;
          mb_status[StatusWriteBit] = 1'b0;
          mail_pend = 1'b0;
          await_desc = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic note_fail(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: hold a beat until it is taken, then advance to the next
  // pending one or idle at random.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (bus_op_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= bus_op_q.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random, or hard while the hold-off runs
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !rx_hold && (calm || $urandom_range(0, 99) >= 10);
    end
  end

  // Hold-off process: keep the receiver stalled for a fixed stretch so the
  // output register fills and the core backs up onto its request port
  always begin
    @(hold_off_ev);
    rx_hold = 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    rx_hold = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted request beat, check every result beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_fire = 1'b0;
    end else begin
      req_fire = req_ch.valid && req_ch.ready;
      if (req_fire) mailbox_out_q.push_back(mailbox_advance(req_ch.data));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (mailbox_out_q.size() == 0) begin
          note_fail($sformatf("unexpected result beat: kind %0d rdata %h",
                              rsp_ch.data.kind, rsp_ch.data.read_data));
        end else begin
          want = mailbox_out_q.pop_front();
          if (rsp_ch.data.kind !== want.kind ||
              rsp_ch.data.read_data !== want.read_data ||
              rsp_ch.data.in_window !== want.in_window ||
              rsp_ch.data.fetch_address !== want.fetch_address ||
              rsp_ch.data.pitch !== want.pitch ||
              rsp_ch.data.buffer_size !== want.buffer_size ||
              rsp_ch.data.buffer_pointer !== want.buffer_pointer) begin
            note_fail($sformatf(
              {"result %0d mismatch: exp kind %0d rdata %h win %0b fetch %h",
               " pitch %0d size %0d ptr %h / got kind %0d rdata %h win %0b",
               " fetch %h pitch %0d size %0d ptr %h"},
              ops_checked, want.kind, want.read_data, want.in_window,
              want.fetch_address, want.pitch, want.buffer_size, want.buffer_pointer,
              rsp_ch.data.kind, rsp_ch.data.read_data, rsp_ch.data.in_window,
              rsp_ch.data.fetch_address, rsp_ch.data.pitch,
              rsp_ch.data.buffer_size, rsp_ch.data.buffer_pointer));
          end
          ops_checked++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t rand_item(logic [OpW-1:0] op);
    in_item_t it;
    it.operation      = op;
    it.bus_address    = $urandom();
    it.write_data     = $urandom();
    it.virtual_width  = DimW'($urandom());
    it.virtual_height = DimW'($urandom());
    it.bit_depth      = DepthW'($urandom());
    return it;
  endfunction

  // Byte address of a window word, with random junk in the ignored low bits
  function automatic logic [AddrW-1:0] word_addr(logic [IdxW-1:0] idx);
    return {win_base[AddrW-1:2], 2'b00} + 32'({idx, 2'b00}) + 32'($urandom_range(0, 3));
  endfunction

  task automatic push_op(in_item_t it);
    bus_op_q.push_back(it);
    ops_queued++;
  endtask

  task automatic bus_access(logic [OpW-1:0] op, logic [IdxW-1:0] idx,
                            logic [WordW-1:0] data);
    in_item_t it;
    it = rand_item(op);
    it.bus_address = word_addr(idx);
    it.write_data = data;
    push_op(it);
  endtask

  task automatic desc_reply(logic [DimW-1:0] w, logic [DimW-1:0] h,
                            logic [DepthW-1:0] d);
    in_item_t it;
    it = rand_item(OP_REPLY);
    it.virtual_width = w;
    it.virtual_height = h;
    it.bit_depth = d;
    push_op(it);
  endtask

  // Any operation; mostly aimed at the window or just past its end
  task automatic noise_op();
    in_item_t it;
    it = rand_item(OP_OPS[$urandom_range(0, 3)]);
    if ($urandom_range(0, 3) != 0) it.bus_address = word_addr(IdxW'($urandom_range(0, 10)));
    push_op(it);
  endtask

  // One well-formed mail round trip with random content and stray beats mixed in
  task automatic mail_exchange();
    logic [DimW-1:0]   w;
    logic [DimW-1:0]   h;
    logic [DepthW-1:0] d;
    w = ($urandom_range(0, 3) == 0) ? DimW'($urandom_range(0, 15)) : DimW'($urandom());
    h = ($urandom_range(0, 3) == 0) ? DimW'($urandom_range(0, 15)) : DimW'($urandom());
    d = ($urandom_range(0, 7) == 0) ? DepthW'($urandom_range(33, 63))
                                    : DepthW'($urandom_range(0, 32));
    // Sometimes clear write-not-ready first so the mail is not lost
    if ($urandom_range(0, 9) < 3) bus_access(OP_WRITE, WORD_STATUS, {1'b0, 31'($urandom())});
    bus_access(OP_WRITE, WORD_WRITE, $urandom());
    repeat ($urandom_range(0, 2)) noise_op();
    push_op(rand_item(OP_TICK));
    repeat ($urandom_range(0, 1)) noise_op();
    desc_reply(w, h, d);
    bus_access(OP_READ, WORD_READ, $urandom());
    if ($urandom_range(0, 1) != 0) bus_access(OP_READ, WORD_STATUS, $urandom());
  endtask

  task automatic wait_drained();
    while (ops_checked != ops_queued) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [WordW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_MAILBOX_BASE) win_base = val;
    else fb_end = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Pause until every result is in, reprogram both registers, then queue a
  // random mix of mail round trips and noise
  task automatic random_phase(logic [WordW-1:0] base, logic [WordW-1:0] end_addr,
                              logic quiet);
    int target;
    wait_drained();
    cfg_write(CFG_MAILBOX_BASE, base);
    cfg_write(CFG_FB_END, end_addr);
    calm <= quiet;
    target = ops_queued + PhaseItems;
    while (ops_queued < target) begin
      if ($urandom_range(0, 9) < 7) mail_exchange();
      else noise_op();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;

    // Predictor starts from the reset state of the core
    win_base   = '0;
    fb_end     = '0;
    mb_read    = '0;
    mb_rsv[0]  = '0;
    mb_rsv[1]  = '0;
    mb_rsv[2]  = '0;
    mb_sender  = '0;
    mb_status  = STATUS_RESET;
    mb_config  = '0;
    mb_write   = '0;
    mail_pend  = 1'b0;
    await_desc = 1'b0;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_write(CFG_MAILBOX_BASE, 32'h0000_1000);
    cfg_write(CFG_FB_END, 32'h3c00_0000);

    // Directed: reset value of every word, poll write ignored, idle tick and
    // stray reply, a mail with a second write while not write-ready, a tick
    // while the descriptor is awaited, the largest frame buffer, accesses
    // just outside the window and a depth above 32 bits
    for (int i = 0; i <= int'(WORD_WRITE); i++) bus_access(OP_READ, IdxW'(i), $urandom());
    bus_access(OP_WRITE, WORD_POLL, 32'h1234_5678);
    bus_access(OP_WRITE, WORD_SENDER, 32'ha5a5_a5a5);
    push_op(rand_item(OP_TICK));
    desc_reply('1, '1, DEPTH_MAX);
    bus_access(OP_WRITE, WORD_WRITE, 32'hffff_ffff);
    push_op(rand_item(OP_TICK));
    push_op(rand_item(OP_TICK));
    bus_access(OP_WRITE, WORD_WRITE, 32'h1234_5677);
    desc_reply('1, '1, DEPTH_MAX);
    bus_access(OP_READ, WORD_READ, $urandom());
    bus_access(OP_READ, IdxW'(9), $urandom());
    bus_access(OP_WRITE, IdxW'(10), 32'hdead_beef);
    bus_access(OP_WRITE, WORD_WRITE, 32'hc000_0003);
    push_op(rand_item(OP_TICK));
    desc_reply(12'd640, 12'd480, 6'd63);

    // Pressure: offer beats back to back while the receiver holds off
    wait_drained();
    calm <= 1'b1;
    repeat (15) mail_exchange();
    @(posedge clk);
    -> hold_off_ev;

    // Random phases over several register settings, extremes included; the
    // wrapped window at the top of the address space is among them
    random_phase(32'h0000_0000, 32'h0000_0000, 1'b0);
    random_phase(32'hffff_fffc, 32'hffff_ffff, 1'b0);
    random_phase($urandom(), $urandom(), 1'b1);
    random_phase(32'h2000_0003, $urandom(), 1'b0);
    random_phase($urandom(), 32'h8000_0000, 1'b0);
    random_phase($urandom(), $urandom(), 1'b0);

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && mailbox_out_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
